// ===== rtl/page_framebuffer_blit_flush_assert.svh =====
// Assertion macros for the framebuffer block; they sample on clk and are
// disabled while rst is high.
`ifndef PAGE_FRAMEBUFFER_BLIT_FLUSH_ASSERT_SVH
`define PAGE_FRAMEBUFFER_BLIT_FLUSH_ASSERT_SVH
`ifndef SYNTHESIS
`define PFB_ASSERT_SAME(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("framebuffer assertion failed");
`define PFB_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("framebuffer assertion failed");
`else
`define PFB_ASSERT_SAME(lbl, a, b)
`define PFB_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// ===== rtl/pfb_pkg.sv =====
`default_nettype none
package pfb_pkg;

  localparam int FRAME_BYTES = 1024;
  localparam int FRAME_AW    = $clog2(FRAME_BYTES);

  localparam logic [2:0] CMD_DRAW  = 3'd0;
  localparam logic [2:0] CMD_FILL  = 3'd1;
  localparam logic [2:0] CMD_SETUP = 3'd2;
  localparam logic [2:0] CMD_BLIT  = 3'd3;
  localparam logic [2:0] CMD_EMIT  = 3'd4;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  localparam logic [7:0] BYTE_CMD_LEAD = 8'h00;
  localparam logic [7:0] BYTE_COL_ADDR = 8'h21;
  localparam logic [7:0] BYTE_PAGE_ADR = 8'h22;
  localparam logic [7:0] BYTE_DATA_LEAD = 8'h40;

  typedef struct packed {
    logic load_item;
    logic geom_dec;
    logic geom_len;
    logic sweep_wr;
    logic sweep_fill;
    logic blit_setup;
    logic blit_start;
    logic blit_adv;
    logic blit_close;
    logic pix_load;
    logic pix_addr;
    logic pix_write;
    logic flush_chk;
    logic emit_sel;
    logic emit_fin;
    logic set_err;
    logic res_load;
  } pfb_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       geom_over;
    logic       sweep_last;
    logic       blit_ok;
    logic       blit_stop;
    logic       out_free;
  } pfb_sts_t;

endpackage
`default_nettype wire

// ===== rtl/pfb_ram.sv =====
`default_nettype none
module pfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/pfb_datapath.sv =====
`default_nettype none
`include "page_framebuffer_blit_flush_assert.svh"
module pfb_datapath import pfb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire pfb_cmd_t    cmd,
  output pfb_sts_t         sts,
  input  wire logic        cfg_valid,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic [39:0] s_axis_tdata,
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  output logic [0:0]       m_axis_tuser
);

  logic [7:0]  panel_w;
  logic [6:0]  panel_h;
  logic [2:0]  it_cmd;
  logic [7:0]  it_x, it_ww, it_bits;
  logic [6:0]  it_y, it_wh;
  logic        it_color;
  logic [3:0]  pages;
  logic [10:0] flen;
  logic [11:0] prod_pw;
  logic [11:0] total;
  logic [6:0]  rows;
  logic        err;

  logic [FRAME_AW-1:0] sw_cnt;

  logic [7:0]  bl_left, bl_cols, bl_col;
  logic [6:0]  bl_top, bl_rows, bl_row;
  logic        bl_armed;
  logic [3:0]  bit_i;
  logic        bl_end;

  logic [8:0]  px;
  logic [7:0]  py;
  logic        pbit;
  logic [13:0] idx_full;
  logic [FRAME_AW-1:0] pix_idx;
  logic        pix_ok;
  logic [7:0]  mask;

  logic [11:0] fpos, fpos_inc;
  logic [5:0]  fch, fof;
  logic [11:0] rem;
  logic [5:0]  clen;
  logic [FRAME_AW-1:0] emit_idx;
  logic [7:0]  em_byte;
  logic        em_first, em_last, em_done;
  logic [7:0]  ev_byte;
  logic        ev_first, ev_last;

  logic        ram_we;
  logic [FRAME_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]  ram_wdata, ram_rdata;
  logic        setup_bad;

  assign prod_pw  = 12'(pages) * 12'(panel_w);
  assign rows     = {pages, 3'b000};
  assign total    = 12'd8 + 12'((13'(flen) + 13'd31) >> 5) + 12'(flen);
  assign bl_end   = bl_row >= bl_rows;
  assign idx_full = 14'(px) + 14'(py[7:3]) * 14'(panel_w);
  assign mask     = 8'd1 << py[2:0];
  assign fpos_inc = fpos + 12'd1;
  assign rem      = {1'b0, flen} - {1'b0, fch, 5'b00000};
  assign clen     = (rem >= 12'd32) ? 6'd32 : rem[5:0];
  assign emit_idx = {fch[4:0], 5'b00000} + FRAME_AW'(fof) - FRAME_AW'(1);
  assign setup_bad = (9'(it_x) + 9'(it_ww) > 9'(panel_w)) ||
                     (8'(it_y) + 8'(it_wh) > 8'(rows));

  assign sts.op         = it_cmd;
  assign sts.geom_over  = (panel_w != 8'd0) && (prod_pw > 12'(FRAME_BYTES));
  assign sts.sweep_last = sw_cnt == {FRAME_AW{1'b1}};
  assign sts.blit_ok    = bl_armed && (bl_cols != 8'd0);
  assign sts.blit_stop  = bl_end || bit_i[3];
  assign sts.out_free   = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    ev_byte  = BYTE_CMD_LEAD;
    ev_first = 1'b0;
    ev_last  = 1'b0;
    if (fpos < 12'd8) begin
      ev_first = fpos[1:0] == 2'd0;
      ev_last  = fpos[1:0] == 2'd3;
      case (fpos[1:0])
        2'd1:    ev_byte = fpos[2] ? BYTE_PAGE_ADR : BYTE_COL_ADDR;
        2'd3:    ev_byte = fpos[2] ? (8'(pages) - 8'd1) : (panel_w - 8'd1);
        default: ev_byte = BYTE_CMD_LEAD;
      endcase
    end else if (fof == 6'd0) begin
      ev_byte  = BYTE_DATA_LEAD;
      ev_first = 1'b1;
    end else begin
      ev_byte = ram_rdata;
      ev_last = fof == clen;
    end
  end

  assign ram_we    = cmd.sweep_wr || (cmd.pix_write && pix_ok);
  assign ram_waddr = cmd.sweep_wr ? sw_cnt : pix_idx;
  assign ram_wdata = cmd.sweep_wr ? {8{cmd.sweep_fill & it_color}} :
                     (pbit ? (ram_rdata | mask) : (ram_rdata & ~mask));
  assign ram_raddr = cmd.emit_sel ? emit_idx : pix_idx;

  pfb_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_w       <= 8'd128;
      panel_h       <= 7'd64;
      sw_cnt        <= '0;
      bl_left       <= '0;
      bl_top        <= '0;
      bl_cols       <= '0;
      bl_rows       <= '0;
      bl_col        <= '0;
      bl_row        <= '0;
      bl_armed      <= 1'b0;
      fpos          <= '0;
      fch           <= '0;
      fof           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_WIDTH) begin
          panel_w <= cfg_data;
        end else begin
          panel_h <= cfg_data[6:0];
        end
      end
      if (cmd.sweep_wr) begin
        sw_cnt <= sw_cnt + FRAME_AW'(1);
      end
      if (cmd.blit_setup) begin
        if (setup_bad) begin
          bl_armed <= 1'b0;
        end else begin
          bl_left  <= it_x;
          bl_top   <= it_y;
          bl_cols  <= it_ww;
          bl_rows  <= it_wh;
          bl_col   <= '0;
          bl_row   <= '0;
          bl_armed <= (it_ww != 8'd0) && (it_wh != 7'd0);
        end
      end
      if (cmd.blit_adv) begin
        if (bl_col + 8'd1 == bl_cols) begin
          bl_col <= '0;
          bl_row <= bl_row + 7'd1;
        end else begin
          bl_col <= bl_col + 8'd1;
        end
      end
      if (cmd.blit_close && bl_end) begin
        bl_armed <= 1'b0;
      end
      if (cmd.flush_chk && (fpos >= total)) begin
        fpos <= '0;
        fch  <= '0;
        fof  <= '0;
      end
      if (cmd.emit_fin) begin
        if (fpos_inc >= total) begin
          fpos <= '0;
          fch  <= '0;
          fof  <= '0;
        end else begin
          fpos <= fpos_inc;
          if (fpos < 12'd8) begin
            fch <= '0;
            fof <= '0;
          end else if (fof == 6'd32) begin
            fch <= fch + 6'd1;
            fof <= '0;
          end else begin
            fof <= fof + 6'd1;
          end
        end
      end
      if (cmd.res_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it_cmd   <= s_axis_tuser;
      it_x     <= s_axis_tdata[7:0];
      it_y     <= s_axis_tdata[14:8];
      it_color <= s_axis_tdata[15];
      it_ww    <= s_axis_tdata[23:16];
      it_wh    <= s_axis_tdata[30:24];
      it_bits  <= s_axis_tdata[38:31];
      pages    <= panel_h[6:3];
      err      <= 1'b0;
      em_byte  <= '0;
      em_first <= 1'b0;
      em_last  <= 1'b0;
      em_done  <= 1'b0;
    end else begin
      if (cmd.geom_dec) begin
        pages <= pages - 4'd1;
      end
      if (cmd.set_err || (cmd.blit_setup && setup_bad) ||
          (cmd.pix_write && !pix_ok)) begin
        err <= 1'b1;
      end
      if (cmd.emit_fin) begin
        em_byte  <= ev_byte;
        em_first <= ev_first;
        em_last  <= ev_last;
        em_done  <= fpos_inc >= total;
      end
    end
    if (cmd.geom_len) begin
      flen <= prod_pw[10:0];
    end
    if (cmd.blit_start) begin
      bit_i <= '0;
    end else if (cmd.blit_adv) begin
      bit_i <= bit_i + 4'd1;
    end
    if (cmd.pix_load) begin
      if (it_cmd == CMD_DRAW) begin
        px   <= 9'(it_x);
        py   <= 8'(it_y);
        pbit <= it_color;
      end else begin
        px   <= 9'(bl_left) + 9'(bl_col);
        py   <= 8'(bl_top) + 8'(bl_row);
        pbit <= it_bits[3'd7 - bit_i[2:0]];
      end
    end
    if (cmd.pix_addr) begin
      pix_idx <= idx_full[FRAME_AW-1:0];
      pix_ok  <= (px < 9'(panel_w)) && (py < 8'(rows)) &&
                 (idx_full < 14'(FRAME_BYTES));
    end
    if (cmd.res_load) begin
      m_axis_tuser <= err;
      m_axis_tdata <= {6'd0, em_done, em_first, em_byte};
      m_axis_tlast <= em_last;
    end
  end

  `PFB_ASSERT_SAME(a_armed_area, bl_armed, (bl_cols != 8'd0) && (bl_rows != 7'd0))
  `PFB_ASSERT_NEXT(a_len_fits, cmd.geom_len, flen <= 11'(FRAME_BYTES))
  `PFB_ASSERT_SAME(a_chunk_off, 1'b1, fof <= 6'd32)

endmodule
`default_nettype wire

// ===== rtl/pfb_ctrl.sv =====
`default_nettype none
module pfb_ctrl import pfb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire pfb_sts_t sts,
  output pfb_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_GEOM, S_LEN, S_DISP, S_FILL, S_PLOAD, S_PADDR,
    S_PRD, S_PWR, S_BNEXT, S_EWRAP, S_ERD, S_EOUT, S_DONE
  } state_t;

  state_t state, state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_GEOM;
        end
      end
      S_GEOM: begin
        if (sts.geom_over) cmd.geom_dec = 1'b1;
        else state_next = S_LEN;
      end
      S_LEN: begin
        cmd.geom_len = 1'b1;
        state_next   = S_DISP;
      end
      S_DISP: begin
        case (sts.op)
          CMD_DRAW: state_next = S_PLOAD;
          CMD_FILL: state_next = S_FILL;
          CMD_SETUP: begin
            cmd.blit_setup = 1'b1;
            state_next     = S_DONE;
          end
          CMD_BLIT: begin
            if (sts.blit_ok) begin
              cmd.blit_start = 1'b1;
              state_next     = S_BNEXT;
            end else begin
              cmd.set_err = 1'b1;
              state_next  = S_DONE;
            end
          end
          CMD_EMIT: state_next = S_EWRAP;
          default: begin
            cmd.set_err = 1'b1;
            state_next  = S_DONE;
          end
        endcase
      end
      S_FILL: begin
        cmd.sweep_wr   = 1'b1;
        cmd.sweep_fill = 1'b1;
        if (sts.sweep_last) state_next = S_DONE;
      end
      S_PLOAD: begin
        cmd.pix_load = 1'b1;
        state_next   = S_PADDR;
      end
      S_PADDR: begin
        cmd.pix_addr = 1'b1;
        state_next   = S_PRD;
      end
      S_PRD: state_next = S_PWR;
      S_PWR: begin
        cmd.pix_write = 1'b1;
        if (sts.op == CMD_BLIT) begin
          cmd.blit_adv = 1'b1;
          state_next   = S_BNEXT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_BNEXT: begin
        if (sts.blit_stop) begin
          cmd.blit_close = 1'b1;
          state_next     = S_DONE;
        end else begin
          state_next = S_PLOAD;
        end
      end
      S_EWRAP: begin
        cmd.flush_chk = 1'b1;
        state_next    = S_ERD;
      end
      S_ERD: begin
        cmd.emit_sel = 1'b1;
        state_next   = S_EOUT;
      end
      S_EOUT: begin
        cmd.emit_fin = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/page_framebuffer_blit_flush.sv =====
// Monochrome page-mode framebuffer, 1024 bytes, one byte per column per page.
// Input words arrive on s_axis: tuser is the command, tdata the operands.
// Each input word yields exactly one result word on m_axis, in order.
// Panel width and height are written on the cfg channel (index 0 width,
// index 1 height); cfg_ready is always high, write only while idle.
// Every command first derives the page geometry: S_GEOM drops one page
// at a time until the frame fits the frame store, then S_LEN sets the length.
// Draw pixel then does a read-modify-write on the dual-port frame RAM
// (S_PLOAD, S_PADDR, S_PRD, S_PWR), blit byte the same per pixel for up to
// eight pixels, emit next S_EWRAP, S_ERD, S_EOUT, fill one byte per cycle;
// blit setup and bad commands go straight to the result in S_DONE.
// Each result leaves through an output register; the next input word is
// taken once the current result is registered, and a stalled receiver
// holds only the last step of the following command.
// After reset the block clears the frame store with s_axis_tready low;
// configuration writes are taken throughout.
`default_nettype none
module page_framebuffer_blit_flush import pfb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // pos_x[7:0] pos_y[14:8] color[15] win_width[23:16] win_height[30:24]
  // bitmap_byte[38:31]
  input  wire logic [39:0] s_axis_tdata,
  // command[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // stream_byte[7:0] transfer_first[8] flush_done[9]
  output logic [15:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  // status[0]
  output logic [0:0]       m_axis_tuser
);

  pfb_cmd_t cmd;
  pfb_sts_t sts;

  assign cfg_ready = 1'b1;

  pfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfb_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
`default_nettype wire
